[hdl/pfaa_pkg.sv]
// Shared types and constants for the polygon fan area accumulator.
// Holds the vertex and result payload structs, the controller state
// encoding and the command bundle that the controller sends the datapath.
`default_nettype none

package pfaa_pkg;

  // Field and datapath widths.
  localparam int COORD_W   = 16;                // Q8.8 coordinate
  localparam int EDGE_W    = COORD_W + 1;       // difference of two coordinates
  localparam int MUL_W     = EDGE_W + 1;        // signed multiplier operand
  localparam int PROD_W    = 2 * MUL_W;         // multiplier product
  localparam int MAG_W     = 34;                // magnitude of one cross component
  localparam int HALF_W    = MAG_W / 2;         // split for partial-product squares
  localparam int SSQ_W     = 70;                // squared cross-product magnitude
  localparam int ROOT_W    = 36;                // square root result
  localparam int RAD_W     = 2 * ROOT_W;        // padded radicand
  localparam int REM_W     = ROOT_W + 2;        // root remainder
  localparam int AREA_W    = 48;                // area accumulator
  localparam int TRI_W     = ROOT_W - 1;        // half of the root

  // Sequencer counts.
  localparam int NUM_MUL_STEPS = 16;
  localparam int SQRT_STEPS    = ROOT_W;
  localparam int STEP_W        = 6;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  // Payload of one input transfer.
  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
    logic                      final_vertex;
  } vertex_t;

  // Payload of one result transfer.
  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic              area_saturated;
  } area_result_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_MUL,
    ST_SQINIT,
    ST_SQRT,
    ST_ACC,
    ST_FINISH
  } pfaa_state_t;

  // Multiplier operand pairs: cross-product terms, then the three partial
  // products of each component square (high*high, high*low, low*low).
  typedef enum logic [3:0] {
    MS_NONE,
    MS_YZ,
    MS_ZY,
    MS_ZX,
    MS_XZ,
    MS_XY,
    MS_YX,
    MS_HH0,
    MS_HL0,
    MS_LL0,
    MS_HH1,
    MS_HL1,
    MS_LL1,
    MS_HH2,
    MS_HL2,
    MS_LL2
  } mul_sel_t;

  // What to do with the registered product.
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD,   // start a cross component
    ACC_SUB,    // finish a cross component and store its magnitude
    ACC_HH,     // add high*high partial product, shifted
    ACC_HL,     // add high*low partial product, doubled and shifted
    ACC_LL      // add low*low partial product
  } acc_op_t;

  // Command bundle from controller to datapath.
  typedef struct packed {
    logic        capture;
    logic        load_base;
    logic        load_prev;
    logic        edge_calc;
    mul_sel_t    mul_sel;
    acc_op_t     acc_op;
    logic [1:0]  acc_axis;
    logic        sqrt_init;
    logic        sqrt_step;
    logic        area_add;
    logic        out_load;
  } pfaa_cmd_t;

endpackage

`default_nettype wire

[hdl/pfaa_datapath.sv]
// Datapath of the polygon fan area accumulator: vertex registers, edge
// vectors, a shared 18x18 multiplier, the square-sum accumulator, a
// two-bit-per-step square root unit and the area sum. Uses pfaa_pkg.
`default_nettype none

module pfaa_datapath
  import pfaa_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire vertex_t       in_data,
  input  wire pfaa_cmd_t     cmd,
  output      area_result_t  out_data
);

  logic signed [COORD_W-1:0] cur_r  [3];
  logic signed [COORD_W-1:0] base_r [3];
  logic signed [COORD_W-1:0] prev_r [3];
  logic signed [EDGE_W-1:0]  e1_r   [3];
  logic signed [EDGE_W-1:0]  e2_r   [3];
  logic        [MAG_W-1:0]   mag_r  [3];

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  cacc_r;
  logic signed [PROD_W-1:0]  diff;
  logic        [PROD_W-1:0]  diff_abs;
  logic        [MAG_W-1:0]   pp;
  logic        [SSQ_W-1:0]   ssq_r;

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              trial_ok;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  logic [AREA_W-1:0] area_r;
  logic              ovf_r;
  logic [AREA_W:0]   area_sum;
  area_result_t      out_r;

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MS_YZ:  begin mul_a = {e1_r[1][EDGE_W-1], e1_r[1]}; mul_b = {e2_r[2][EDGE_W-1], e2_r[2]}; end
      MS_ZY:  begin mul_a = {e1_r[2][EDGE_W-1], e1_r[2]}; mul_b = {e2_r[1][EDGE_W-1], e2_r[1]}; end
      MS_ZX:  begin mul_a = {e1_r[2][EDGE_W-1], e1_r[2]}; mul_b = {e2_r[0][EDGE_W-1], e2_r[0]}; end
      MS_XZ:  begin mul_a = {e1_r[0][EDGE_W-1], e1_r[0]}; mul_b = {e2_r[2][EDGE_W-1], e2_r[2]}; end
      MS_XY:  begin mul_a = {e1_r[0][EDGE_W-1], e1_r[0]}; mul_b = {e2_r[1][EDGE_W-1], e2_r[1]}; end
      MS_YX:  begin mul_a = {e1_r[1][EDGE_W-1], e1_r[1]}; mul_b = {e2_r[0][EDGE_W-1], e2_r[0]}; end
      MS_HH0: begin mul_a = {1'b0, mag_r[0][MAG_W-1:HALF_W]}; mul_b = {1'b0, mag_r[0][MAG_W-1:HALF_W]}; end
      MS_HL0: begin mul_a = {1'b0, mag_r[0][MAG_W-1:HALF_W]}; mul_b = {1'b0, mag_r[0][HALF_W-1:0]}; end
      MS_LL0: begin mul_a = {1'b0, mag_r[0][HALF_W-1:0]};     mul_b = {1'b0, mag_r[0][HALF_W-1:0]}; end
      MS_HH1: begin mul_a = {1'b0, mag_r[1][MAG_W-1:HALF_W]}; mul_b = {1'b0, mag_r[1][MAG_W-1:HALF_W]}; end
      MS_HL1: begin mul_a = {1'b0, mag_r[1][MAG_W-1:HALF_W]}; mul_b = {1'b0, mag_r[1][HALF_W-1:0]}; end
      MS_LL1: begin mul_a = {1'b0, mag_r[1][HALF_W-1:0]};     mul_b = {1'b0, mag_r[1][HALF_W-1:0]}; end
      MS_HH2: begin mul_a = {1'b0, mag_r[2][MAG_W-1:HALF_W]}; mul_b = {1'b0, mag_r[2][MAG_W-1:HALF_W]}; end
      MS_HL2: begin mul_a = {1'b0, mag_r[2][MAG_W-1:HALF_W]}; mul_b = {1'b0, mag_r[2][HALF_W-1:0]}; end
      MS_LL2: begin mul_a = {1'b0, mag_r[2][HALF_W-1:0]};     mul_b = {1'b0, mag_r[2][HALF_W-1:0]}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Finishing a cross component: difference and its magnitude.
  assign diff     = cacc_r - prod_r;
  assign diff_abs = diff[PROD_W-1] ? (PROD_W'(0) - diff) : diff;
  assign pp       = prod_r[MAG_W-1:0];

  // One step of the restoring square root, two radicand bits per step.
  assign rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial    = {1'b0, root_r[ROOT_W-2:0], 2'b01};
  assign trial_ok = (rem_sh >= trial);
  assign rem_nxt  = trial_ok ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {root_r[ROOT_W-2:0], trial_ok};

  // Saturating add of the finished triangle.
  assign area_sum = {1'b0, area_r} + (AREA_W + 1)'(root_r[ROOT_W-1:1]);

  // Vertex and edge registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r[0] <= in_data.vx;
      cur_r[1] <= in_data.vy;
      cur_r[2] <= in_data.vz;
    end
    if (cmd.load_base) begin
      base_r <= cur_r;
    end
    if (cmd.load_prev) begin
      prev_r <= cur_r;
    end
    if (cmd.edge_calc) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= {prev_r[i][COORD_W-1], prev_r[i]} - {base_r[i][COORD_W-1], base_r[i]};
        e2_r[i] <= {cur_r[i][COORD_W-1], cur_r[i]} - {base_r[i][COORD_W-1], base_r[i]};
      end
    end
  end

  // Multiplier output register and product accumulation.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.edge_calc) begin
      ssq_r <= '0;
    end else begin
      case (cmd.acc_op)
        ACC_LOAD: cacc_r <= prod_r;
        ACC_SUB:  mag_r[cmd.acc_axis] <= diff_abs[MAG_W-1:0];
        ACC_HH:   ssq_r <= ssq_r + (SSQ_W'(pp) << (2 * HALF_W));
        ACC_HL:   ssq_r <= ssq_r + (SSQ_W'(pp) << (HALF_W + 1));
        ACC_LL:   ssq_r <= ssq_r + SSQ_W'(pp);
        default:  ssq_r <= ssq_r;
      endcase
    end
  end

  // Square root unit.
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rad_r  <= RAD_W'(ssq_r);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  // Area sum, overflow flag and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.out_load) begin
      area_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.area_add) begin
      if (area_sum[AREA_W]) begin
        area_r <= AREA_MAX;
        ovf_r  <= 1'b1;
      end else begin
        area_r <= area_sum[AREA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.area           <= area_r;
      out_r.area_saturated <= ovf_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[hdl/pfaa_controller.sv]
// Controller of the polygon fan area accumulator: state machine, step
// counter, vertex counter and result valid. Drives the datapath through
// the command bundle from pfaa_pkg.
`default_nettype none

module pfaa_controller
  import pfaa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_final,
  output      logic       in_stall,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      pfaa_cmd_t  cmd
);

  localparam logic [STEP_W-1:0] LAST_MUL_STEP  = STEP_W'(NUM_MUL_STEPS - 1);
  localparam logic [STEP_W-1:0] LAST_SQRT_STEP = STEP_W'(SQRT_STEPS - 1);
  localparam logic [1:0]        VSEEN_MAX      = 2'd2;

  pfaa_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        vseen_r, vseen_nxt;
  logic              final_r, final_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  // The result register is free when empty or drained in this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      vseen_r     <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      vseen_r     <= vseen_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    vseen_nxt     = vseen_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.mul_sel   = MS_NONE;
    cmd.acc_op    = ACC_NONE;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          final_nxt   = in_final;
          state_nxt   = (vseen_r == VSEEN_MAX) ? ST_EDGE : ST_FINISH;
        end
      end

      ST_EDGE: begin
        cmd.edge_calc = 1'b1;
        step_nxt      = '0;
        state_nxt     = ST_MUL;
      end

      // Cross products first, then the squares of the three components.
      // The accumulate action always concerns the previous cycle's product.
      ST_MUL: begin
        case (step_r[3:0])
          4'd0:  begin cmd.mul_sel = MS_YZ;  end
          4'd1:  begin cmd.mul_sel = MS_ZY;  cmd.acc_op = ACC_LOAD; end
          4'd2:  begin cmd.mul_sel = MS_ZX;  cmd.acc_op = ACC_SUB; cmd.acc_axis = 2'd0; end
          4'd3:  begin cmd.mul_sel = MS_XZ;  cmd.acc_op = ACC_LOAD; end
          4'd4:  begin cmd.mul_sel = MS_XY;  cmd.acc_op = ACC_SUB; cmd.acc_axis = 2'd1; end
          4'd5:  begin cmd.mul_sel = MS_YX;  cmd.acc_op = ACC_LOAD; end
          4'd6:  begin cmd.mul_sel = MS_HH0; cmd.acc_op = ACC_SUB; cmd.acc_axis = 2'd2; end
          4'd7:  begin cmd.mul_sel = MS_HL0; cmd.acc_op = ACC_HH; end
          4'd8:  begin cmd.mul_sel = MS_LL0; cmd.acc_op = ACC_HL; end
          4'd9:  begin cmd.mul_sel = MS_HH1; cmd.acc_op = ACC_LL; end
          4'd10: begin cmd.mul_sel = MS_HL1; cmd.acc_op = ACC_HH; end
          4'd11: begin cmd.mul_sel = MS_LL1; cmd.acc_op = ACC_HL; end
          4'd12: begin cmd.mul_sel = MS_HH2; cmd.acc_op = ACC_LL; end
          4'd13: begin cmd.mul_sel = MS_HL2; cmd.acc_op = ACC_HH; end
          4'd14: begin cmd.mul_sel = MS_LL2; cmd.acc_op = ACC_HL; end
          default: begin cmd.mul_sel = MS_NONE; cmd.acc_op = ACC_LL; end
        endcase
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_MUL_STEP) begin
          state_nxt = ST_SQINIT;
        end
      end

      ST_SQINIT: begin
        cmd.sqrt_init = 1'b1;
        step_nxt      = '0;
        state_nxt     = ST_SQRT;
      end

      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == LAST_SQRT_STEP) begin
          state_nxt = ST_ACC;
        end
      end

      ST_ACC: begin
        cmd.area_add = 1'b1;
        state_nxt    = ST_FINISH;
      end

      // Commit the vertex; a last vertex also needs a free result register.
      ST_FINISH: begin
        if (!final_r || out_free) begin
          cmd.load_prev = 1'b1;
          cmd.load_base = (vseen_r == 2'd0);
          vseen_nxt     = (vseen_r == VSEEN_MAX) ? VSEEN_MAX : vseen_r + 1'b1;
          if (final_r) begin
            cmd.out_load  = 1'b1;
            out_valid_nxt = 1'b1;
            vseen_nxt     = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The vertex counter saturates at two.
  a_vseen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    vseen_r != 2'd3)
    else $error("vertex counter passed its saturation value");

  // A result is loaded only into a free result register.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register overwritten before its transfer");

  // A loaded result is offered in the next cycle.
  a_out_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not offered");

  // A vertex that closes a triangle starts the edge computation.
  a_tri_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && vseen_r == VSEEN_MAX) |=> state_r == ST_EDGE)
    else $error("triangle vertex did not start the datapath");

  // Only the last vertex of a polygon produces a result.
  a_load_final: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> final_r)
    else $error("result produced for a vertex that is not the last");

endmodule

`default_nettype wire

[hdl/polygon_fan_area_accumulator.sv]
// The first two vertices of a polygon are only captured and committed; every later
// vertex runs, before the next input transfer, through the edge computation, the
// shared 18x18 multiplier and the square root unit (two radicand bits a cycle),
// then the area add and the commit.
// A result is offered in the cycle after the last vertex commits; a last vertex
// waits in the commit cycle for as long as the previous result is still stalled.
// Synchronous active-low reset clears the controller, vertex count and area sum.
`default_nettype none

module polygon_fan_area_accumulator
  import pfaa_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire vertex_t       in_data,
  output      logic          out_valid,
  input  wire logic          out_stall,
  output      area_result_t  out_data
);

  pfaa_cmd_t cmd;

  // Sequencing and handshakes.
  pfaa_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_final  (in_data.final_vertex),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  pfaa_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
